### rtl/core/entity_id_allocator_with_bitsets_assert.svh
// Assertion macros for the entity table block; empty when synthesized.
`ifndef ENTITY_ID_ALLOCATOR_WITH_BITSETS_ASSERT_SVH
`define ENTITY_ID_ALLOCATOR_WITH_BITSETS_ASSERT_SVH
`ifndef SYNTHESIS
`define EIA_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("entity table assertion failed");
`define EIA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("entity table assertion failed");
`define EIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("entity table assertion failed");
`else
`define EIA_ASSERT_ALWAYS(label, expr)
`define EIA_ASSERT_IMPL(label, ante, cons)
`define EIA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/eia_pkg.sv
// Shared types and constants for the entity table block.
package eia_pkg;

  localparam int ENTITIES_DEF   = 1024;
  localparam int COMP_TYPES_DEF = 64;
  localparam int MODE_W         = 3;
  localparam int ENT_W          = 10;
  localparam int COMP_W         = 6;
  localparam int STATUS_W       = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 3'd0,
    MODE_RELEASE = 3'd1,
    MODE_CLEAR   = 3'd2,
    MODE_ADD     = 3'd3,
    MODE_REMOVE  = 3'd4,
    MODE_TEST    = 3'd5,
    MODE_LIST    = 3'd6,
    MODE_NONE    = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_DEAD    = 3'd2,
    ST_PRESENT = 3'd3,
    ST_ABSENT  = 3'd4,
    ST_RANGE   = 3'd5,
    ST_FULL    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic              hit;
    logic              fin;
    logic [COMP_W-1:0] idx;
  } scan_sts_t;

endpackage

### rtl/core/eia_in_if.sv
// Command channel: valid/ready handshake with the request fields.
interface eia_in_if;
  logic                       valid;
  logic                       ready;
  logic [eia_pkg::MODE_W-1:0] mode;
  logic [eia_pkg::ENT_W-1:0]  entity_id;
  logic [eia_pkg::COMP_W-1:0] component_id;

  modport source (output valid, output mode, output entity_id, output component_id,
                  input ready);
  modport sink (input valid, input mode, input entity_id, input component_id,
                output ready);
endinterface

### rtl/core/eia_out_if.sv
// Result channel: valid/ready handshake with the result fields.
interface eia_out_if;
  logic                         valid;
  logic                         ready;
  logic [eia_pkg::ENT_W-1:0]    result_entity;
  logic                         present;
  logic [eia_pkg::COMP_W-1:0]   listed_component;
  logic                         found;
  logic                         last;
  logic [eia_pkg::STATUS_W-1:0] status;

  modport source (output valid, output result_entity, output present,
                  output listed_component, output found, output last, output status,
                  input ready);
  modport sink (input valid, input result_entity, input present,
                input listed_component, input found, input last, input status,
                output ready);
endinterface

### rtl/core/eia_scan.sv
// Component bitmap walker: shifts the bitmap one place a cycle while ctl.step is set, lowest bit first.
module eia_scan #(
  parameter int COMPONENT_TYPES = eia_pkg::COMP_TYPES_DEF
) (
  input  logic                       clk,
  input  eia_pkg::scan_ctl_t         ctl,
  input  logic [COMPONENT_TYPES-1:0] bits,
  output eia_pkg::scan_sts_t         sts
);

  logic [COMPONENT_TYPES-1:0] scan;
  logic [eia_pkg::COMP_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      scan <= bits;
      idx  <= '0;
    end else if (ctl.step) begin
      scan <= scan >> 1;
      idx  <= idx + 1'b1;
    end
  end

  always_comb begin
    sts.hit = scan[0];
    // final set bit when nothing remains above it
    sts.fin = ((scan >> 1) == '0);
    sts.idx = idx;
  end

endmodule

### rtl/core/entity_id_allocator_with_bitsets.sv
// Top level of the entity table: free-ID stack, alive flags and component bitmaps.
// After reset the block runs a clearing pass over ENTITIES entries (1024 by default)
// that loads the free-ID stack and zeroes the flags and bitmaps; cmd.ready stays low
// meanwhile. It then takes one command at a time: a command is accepted in the idle
// state, the memories are read at that edge, and in the exec state, once the result
// register is free, the block computes the result, writes the memories back and loads
// the result register. List walks the bitmap through one shifting register at one bit
// per cycle, holding on each set bit while the result side stalls. Mode 7 gives no
// result and the block stays idle.
module entity_id_allocator_with_bitsets #(
  parameter int ENTITIES        = eia_pkg::ENTITIES_DEF,
  parameter int COMPONENT_TYPES = eia_pkg::COMP_TYPES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  eia_in_if.sink           cmd,
  eia_out_if.source        rsp
);

  localparam int IdW  = $clog2(ENTITIES);
  localparam int CntW = $clog2(ENTITIES + 1);
  localparam int CT   = COMPONENT_TYPES;
  localparam logic [CntW-1:0] FULL_CNT = CntW'(ENTITIES);
  localparam logic [IdW-1:0]  LAST_ID  = IdW'(ENTITIES - 1);

  eia_pkg::state_t  state, state_next;
  logic [CntW-1:0]  stack_count, stack_count_next;
  logic [IdW-1:0]   init_idx;

  eia_pkg::mode_t             req_mode;
  logic [eia_pkg::ENT_W-1:0]  req_ent;
  logic [eia_pkg::COMP_W-1:0] req_comp;
  logic                       req_oob;
  logic [IdW-1:0]             req_idx;
  logic                       comp_oob;
  logic [CT-1:0]              comp_mask;
  logic                       comp_hit;

  logic [IdW-1:0] stack_mem [ENTITIES];
  logic           alive_mem [ENTITIES];
  logic [CT-1:0]  bits_mem  [ENTITIES];
  logic [IdW-1:0] stack_q;
  logic           alive_q;
  logic [CT-1:0]  bits_q;

  logic           accept;
  logic [IdW-1:0] stk_raddr, tbl_raddr;
  logic           stk_we, alive_we, bits_we;
  logic [IdW-1:0] stk_waddr, stk_wdata, alive_waddr, bits_waddr;
  logic           alive_wdata;
  logic [CT-1:0]  bits_wdata;

  logic                         out_valid, out_free, out_load;
  logic [eia_pkg::ENT_W-1:0]    out_ent, o_ent;
  logic                         out_present, o_present;
  logic [eia_pkg::COMP_W-1:0]   out_comp, o_comp;
  logic                         out_found, o_found;
  logic                         out_last, o_last;
  eia_pkg::status_t             out_status, o_status;

  eia_pkg::scan_ctl_t scan_ctl;
  eia_pkg::scan_sts_t scan_sts;

  assign cmd.ready = (state == eia_pkg::S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign stk_raddr = IdW'(stack_count - CntW'(1));
  assign tbl_raddr = IdW'(cmd.entity_id);
  assign req_idx   = IdW'(req_ent);
  assign comp_oob  = (32'(req_comp) >= CT);
  assign comp_mask = CT'(1) << req_comp;
  assign comp_hit  = |(bits_q & comp_mask);

  eia_scan #(
    .COMPONENT_TYPES(COMPONENT_TYPES)
  ) u_scan (
    .clk (clk),
    .ctl (scan_ctl),
    .bits(bits_q),
    .sts (scan_sts)
  );

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (accept) begin
      stack_q <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (alive_we) begin
      alive_mem[alive_waddr] <= alive_wdata;
    end
    if (accept) begin
      alive_q <= alive_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (bits_we) begin
      bits_mem[bits_waddr] <= bits_wdata;
    end
    if (accept) begin
      bits_q <= bits_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= eia_pkg::S_INIT;
      stack_count <= FULL_CNT;
      init_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      if (state == eia_pkg::S_INIT) begin
        init_idx <= init_idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= eia_pkg::mode_t'(cmd.mode);
      req_ent  <= cmd.entity_id;
      req_comp <= cmd.component_id;
      req_oob  <= (32'(cmd.entity_id) >= ENTITIES);
    end
    if (out_load) begin
      out_ent     <= o_ent;
      out_present <= o_present;
      out_comp    <= o_comp;
      out_found   <= o_found;
      out_last    <= o_last;
      out_status  <= o_status;
    end
  end

  always_comb begin
    state_next       = state;
    stack_count_next = stack_count;
    stk_we           = 1'b0;
    stk_waddr        = '0;
    stk_wdata        = '0;
    alive_we         = 1'b0;
    alive_waddr      = '0;
    alive_wdata      = 1'b0;
    bits_we          = 1'b0;
    bits_waddr       = '0;
    bits_wdata       = '0;
    out_load         = 1'b0;
    o_ent            = req_ent;
    o_present        = 1'b0;
    o_comp           = '0;
    o_found          = 1'b0;
    o_last           = 1'b1;
    o_status         = eia_pkg::ST_OK;
    scan_ctl         = '0;

    case (state)
      eia_pkg::S_INIT: begin
        // load the stack with ID 0 on top, zero flags and bitmaps
        stk_we      = 1'b1;
        stk_waddr   = init_idx;
        stk_wdata   = LAST_ID - init_idx;
        alive_we    = 1'b1;
        alive_waddr = init_idx;
        bits_we     = 1'b1;
        bits_waddr  = init_idx;
        if (init_idx == LAST_ID) begin
          state_next = eia_pkg::S_IDLE;
        end
      end
      eia_pkg::S_IDLE: begin
        if (accept && (eia_pkg::mode_t'(cmd.mode) != eia_pkg::MODE_NONE)) begin
          state_next = eia_pkg::S_EXEC;
        end
      end
      eia_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = eia_pkg::S_IDLE;
          out_load   = 1'b1;
          if (req_mode == eia_pkg::MODE_ALLOC) begin
            if (stack_count == '0) begin
              o_ent    = '0;
              o_status = eia_pkg::ST_NO_FREE;
            end else begin
              o_ent            = eia_pkg::ENT_W'(stack_q);
              stack_count_next = stack_count - 1'b1;
              alive_we         = 1'b1;
              alive_waddr      = stack_q;
              alive_wdata      = 1'b1;
            end
          end else if (req_oob) begin
            o_status = eia_pkg::ST_RANGE;
          end else begin
            case (req_mode)
              eia_pkg::MODE_RELEASE: begin
                if (stack_count >= FULL_CNT) begin
                  o_status = eia_pkg::ST_FULL;
                end else begin
                  stk_we           = 1'b1;
                  stk_waddr        = IdW'(stack_count);
                  stk_wdata        = req_idx;
                  stack_count_next = stack_count + 1'b1;
                end
              end
              eia_pkg::MODE_CLEAR: begin
                alive_we    = 1'b1;
                alive_waddr = req_idx;
                bits_we     = 1'b1;
                bits_waddr  = req_idx;
              end
              eia_pkg::MODE_LIST: begin
                // an empty bitmap answers at once; otherwise hand it to the walker
                if (bits_q != '0) begin
                  out_load      = 1'b0;
                  scan_ctl.load = 1'b1;
                  state_next    = eia_pkg::S_LIST;
                end
              end
              eia_pkg::MODE_ADD, eia_pkg::MODE_REMOVE, eia_pkg::MODE_TEST: begin
                if (comp_oob) begin
                  o_comp   = req_comp;
                  o_status = eia_pkg::ST_RANGE;
                end else if (req_mode == eia_pkg::MODE_TEST) begin
                  o_present = comp_hit;
                end else if (!alive_q) begin
                  o_status = eia_pkg::ST_DEAD;
                end else if (req_mode == eia_pkg::MODE_ADD) begin
                  if (comp_hit) begin
                    o_status = eia_pkg::ST_PRESENT;
                  end else begin
                    bits_we    = 1'b1;
                    bits_waddr = req_idx;
                    bits_wdata = bits_q | comp_mask;
                  end
                end else begin
                  if (!comp_hit) begin
                    o_status = eia_pkg::ST_ABSENT;
                  end else begin
                    bits_we    = 1'b1;
                    bits_waddr = req_idx;
                    bits_wdata = bits_q & ~comp_mask;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      eia_pkg::S_LIST: begin
        if (scan_sts.hit) begin
          // hold on a set bit until the result register frees up
          if (out_free) begin
            out_load      = 1'b1;
            o_comp        = scan_sts.idx;
            o_found       = 1'b1;
            o_last        = scan_sts.fin;
            scan_ctl.step = 1'b1;
            if (scan_sts.fin) begin
              state_next = eia_pkg::S_IDLE;
            end
          end
        end else begin
          scan_ctl.step = 1'b1;
        end
      end
      default: begin
        state_next = eia_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp.valid            = out_valid;
  assign rsp.result_entity    = out_ent;
  assign rsp.present          = out_present;
  assign rsp.listed_component = out_comp;
  assign rsp.found            = out_found;
  assign rsp.last             = out_last;
  assign rsp.status           = out_status;

`include "entity_id_allocator_with_bitsets_assert.svh"

  `EIA_ASSERT_ALWAYS(a_count_range, stack_count <= FULL_CNT)
  `EIA_ASSERT_IMPL(a_init_quiet, state == eia_pkg::S_INIT, !out_valid && !cmd.ready)
  `EIA_ASSERT_NEXT(a_alloc_pop, state == eia_pkg::S_EXEC && req_mode == eia_pkg::MODE_ALLOC && out_free && stack_count != '0, stack_count == $past(stack_count) - 1'b1)
  `EIA_ASSERT_IMPL(a_list_mode, state == eia_pkg::S_LIST, req_mode == eia_pkg::MODE_LIST)

endmodule

### test/tb_top.sv
// Testbench for the entity table: drives commands, predicts every response and checks it.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_IDS     = eia_pkg::ENTITIES_DEF;
  localparam int NUM_COMPS   = eia_pkg::COMP_TYPES_DEF;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [eia_pkg::ENT_W-1:0]  ent;
    logic                       present;
    logic [eia_pkg::COMP_W-1:0] comp;
    logic                       found;
    logic                       last;
    eia_pkg::status_t           status;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_on = 1'b0;
  int   err_count = 0;

  eia_in_if  cmd ();
  eia_out_if rsp ();

  entity_id_allocator_with_bitsets dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // Shadow copy of the entity table
  logic [eia_pkg::ENT_W-1:0] free_ids [NUM_IDS];
  int                        free_cnt;
  bit                        alive [NUM_IDS];
  logic [63:0]               comp_bits [NUM_IDS];
  table_rsp_t                expected_rsp [$];

  table_rsp_t got_rsp;
  table_rsp_t want_rsp;

  always #6 clk = ~clk;

  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void reset_table();
    for (int k = 0; k < NUM_IDS; k++) begin
      free_ids[k]  = eia_pkg::ENT_W'(NUM_IDS - 1 - k);
      alive[k]     = 1'b0;
      comp_bits[k] = '0;
    end
    free_cnt = NUM_IDS;
  endfunction

  function automatic void expect_rsp(logic [eia_pkg::ENT_W-1:0] ent, logic pres,
                                     logic [eia_pkg::COMP_W-1:0] comp,
                                     logic fnd, logic lst, eia_pkg::status_t st);
    table_rsp_t r;
    r.ent     = ent;
    r.present = pres;
    r.comp    = comp;
    r.found   = fnd;
    r.last    = lst;
    r.status  = st;
    expected_rsp.insert(expected_rsp.size(), r);
  endfunction

  function automatic void predict_cmd(eia_pkg::mode_t m, logic [eia_pkg::ENT_W-1:0] ent,
                                      logic [eia_pkg::COMP_W-1:0] comp);
    logic [eia_pkg::ENT_W-1:0] id;
    logic [63:0]               bits;
    if (m == eia_pkg::MODE_NONE) return;
    if (m == eia_pkg::MODE_ALLOC) begin
      if (free_cnt == 0) begin
        expect_rsp('0, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_NO_FREE);
      end else begin
        free_cnt--;
        id = free_ids[free_cnt];
        alive[id] = 1'b1;
        expect_rsp(id, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_OK);
      end
      return;
    end
    if (int'(ent) >= NUM_IDS) begin
      expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_RANGE);
      return;
    end
    case (m)
      eia_pkg::MODE_RELEASE: begin
        if (free_cnt >= NUM_IDS) begin
          expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_FULL);
        end else begin
          // push even when the id is already free or still alive
          free_ids[free_cnt] = ent;
          free_cnt++;
          expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_OK);
        end
      end
      eia_pkg::MODE_CLEAR: begin
        alive[ent]     = 1'b0;
        comp_bits[ent] = '0;
        expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_OK);
      end
      eia_pkg::MODE_LIST: begin
        bits = comp_bits[ent];
        if (bits == '0) begin
          expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_OK);
        end else begin
          for (int c = 0; c < NUM_COMPS; c++) begin
            if (bits[c]) expect_rsp(ent, 1'b0, eia_pkg::COMP_W'(c), 1'b1,
                                    (bits >> c) == 64'd1, eia_pkg::ST_OK);
          end
        end
      end
      default: begin
        if (int'(comp) >= NUM_COMPS) begin
          expect_rsp(ent, 1'b0, comp, 1'b0, 1'b1, eia_pkg::ST_RANGE);
        end else if (m == eia_pkg::MODE_TEST) begin
          // no alive check on test
          expect_rsp(ent, comp_bits[ent][comp], '0, 1'b0, 1'b1, eia_pkg::ST_OK);
        end else if (!alive[ent]) begin
          expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_DEAD);
        end else if (m == eia_pkg::MODE_ADD) begin
          if (comp_bits[ent][comp]) begin
            expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_PRESENT);
          end else begin
            comp_bits[ent][comp] = 1'b1;
            expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_OK);
          end
        end else begin
          if (!comp_bits[ent][comp]) begin
            expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_ABSENT);
          end else begin
            comp_bits[ent][comp] = 1'b0;
            expect_rsp(ent, 1'b0, '0, 1'b0, 1'b1, eia_pkg::ST_OK);
          end
        end
      end
    endcase
  endfunction

  // Send one item and update the shadow table once it is taken
  task automatic issue_cmd(eia_pkg::mode_t m, logic [eia_pkg::ENT_W-1:0] ent,
                           logic [eia_pkg::COMP_W-1:0] comp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.mode         <= m;
    cmd.entity_id    <= ent;
    cmd.component_id <= comp;
    do @(posedge clk); while (!cmd.ready);
    predict_cmd(m, ent, comp);
  endtask

  // Result side: random stall bursts while idling is on
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      got_rsp.ent     = rsp.result_entity;
      got_rsp.present = rsp.present;
      got_rsp.comp    = rsp.listed_component;
      got_rsp.found   = rsp.found;
      got_rsp.last    = rsp.last;
      got_rsp.status  = eia_pkg::status_t'(rsp.status);
      if (expected_rsp.size() == 0) begin
        flag_error($sformatf("unexpected item: ent=%0d comp=%0d status=%0d",
                             got_rsp.ent, got_rsp.comp, rsp.status));
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (got_rsp !== want_rsp) begin
          flag_error($sformatf({"mismatch: expected ent=%0d present=%0b comp=%0d found=%0b ",
                                "last=%0b status=%0d, got ent=%0d present=%0b comp=%0d ",
                                "found=%0b last=%0b status=%0d"},
                               want_rsp.ent, want_rsp.present, want_rsp.comp, want_rsp.found,
                               want_rsp.last, want_rsp.status, got_rsp.ent, got_rsp.present,
                               got_rsp.comp, got_rsp.found, got_rsp.last, rsp.status));
        end
      end
    end
  end

  // Table straight after reset: full stack, dead entities, empty bitmaps
  task automatic test_idle_table();
    issue_cmd(eia_pkg::MODE_RELEASE, 10'd5, 6'd0);
    issue_cmd(eia_pkg::MODE_TEST, 10'd1023, 6'd63);
    issue_cmd(eia_pkg::MODE_LIST, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_ADD, 10'd1023, 6'd63);
    issue_cmd(eia_pkg::MODE_REMOVE, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_NONE, 10'd1023, 6'd63);
  endtask

  task automatic test_component_flow();
    issue_cmd(eia_pkg::MODE_ALLOC, 10'd1023, 6'd63);
    issue_cmd(eia_pkg::MODE_ALLOC, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_ADD, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_ADD, 10'd0, 6'd63);
    issue_cmd(eia_pkg::MODE_ADD, 10'd0, 6'd63);
    issue_cmd(eia_pkg::MODE_TEST, 10'd0, 6'd63);
    issue_cmd(eia_pkg::MODE_LIST, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_REMOVE, 10'd0, 6'd5);
    issue_cmd(eia_pkg::MODE_REMOVE, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_LIST, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_CLEAR, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_TEST, 10'd0, 6'd63);
    issue_cmd(eia_pkg::MODE_ADD, 10'd0, 6'd1);
    // double release hands the same id out twice
    issue_cmd(eia_pkg::MODE_RELEASE, 10'd1, 6'd0);
    issue_cmd(eia_pkg::MODE_RELEASE, 10'd1, 6'd0);
    issue_cmd(eia_pkg::MODE_ALLOC, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_ALLOC, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_ADD, 10'd1, 6'd42);
    issue_cmd(eia_pkg::MODE_LIST, 10'd1, 6'd0);
  endtask

  // Released ids come back last in, first out
  task automatic test_stack_order();
    issue_cmd(eia_pkg::MODE_RELEASE, 10'd700, 6'd0);
    issue_cmd(eia_pkg::MODE_RELEASE, 10'd33, 6'd0);
    issue_cmd(eia_pkg::MODE_ALLOC, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_ALLOC, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_ALLOC, 10'd0, 6'd0);
    issue_cmd(eia_pkg::MODE_CLEAR, 10'd33, 6'd0);
    issue_cmd(eia_pkg::MODE_ADD, 10'd33, 6'd7);
  endtask

  task automatic test_random_traffic(int n_items);
    logic [eia_pkg::ENT_W-1:0]  work_ids [16];
    logic [eia_pkg::ENT_W-1:0]  e;
    logic [eia_pkg::COMP_W-1:0] c;
    eia_pkg::mode_t             m;
    int                         r;
    int                         sent;
    sent = 0;
    // focus on a small working set so bitmaps fill up
    foreach (work_ids[i]) work_ids[i] = eia_pkg::ENT_W'($urandom_range(0, NUM_IDS - 1));
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 10)      m = eia_pkg::MODE_ALLOC;
      else if (r < 18) m = eia_pkg::MODE_RELEASE;
      else if (r < 24) m = eia_pkg::MODE_CLEAR;
      else if (r < 46) m = eia_pkg::MODE_ADD;
      else if (r < 60) m = eia_pkg::MODE_REMOVE;
      else if (r < 76) m = eia_pkg::MODE_TEST;
      else if (r < 94) m = eia_pkg::MODE_LIST;
      else             m = eia_pkg::MODE_NONE;
      if ($urandom_range(0, 3) == 0) e = eia_pkg::ENT_W'($urandom_range(0, NUM_IDS - 1));
      else                           e = work_ids[$urandom_range(0, 15)];
      if ($urandom_range(0, 1) == 0) c = eia_pkg::COMP_W'($urandom_range(0, 63));
      else                           c = eia_pkg::COMP_W'($urandom_range(0, 11));
      issue_cmd(m, e, c);
      if (m != eia_pkg::MODE_NONE) sent++;
    end
  endtask

  initial begin
    cmd.valid        <= 1'b0;
    cmd.mode         <= eia_pkg::MODE_NONE;
    cmd.entity_id    <= '0;
    cmd.component_id <= '0;
    reset_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_idle_table();
    test_component_flow();
    test_stack_order();
    test_random_traffic(220);
    idle_on = 1'b0;
    test_random_traffic(100);
    cmd.valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && expected_rsp.size() != 0; w++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      flag_error($sformatf("%0d expected items never arrived", expected_rsp.size()));
    end
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
